// ----- rtl/bcc_pkg.sv -----
// Package with the shared types, codes and reset values of the button click classifier.
package bcc_pkg;

  localparam int CNT_W = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_IN     = 3'd4,
    EV_OUT    = 3'd5
  } ev_t;

  localparam logic [1:0] MODE_CLICK   = 2'd0;
  localparam logic [1:0] MODE_BOTHWAY = 2'd1;
  localparam logic [1:0] MODE_COMBO   = 2'd2;

  localparam logic [2:0] REG_REST_LEVEL = 3'd0;
  localparam logic [2:0] REG_MODE       = 3'd1;
  localparam logic [2:0] REG_SHORT      = 3'd2;
  localparam logic [2:0] REG_LONG       = 3'd3;
  localparam logic [2:0] REG_DOUBLE_GAP = 3'd4;
  localparam logic [2:0] REG_EDGE       = 3'd5;

  localparam logic [CNT_W-1:0] SHORT_RESET      = 16'd20;
  localparam logic [CNT_W-1:0] LONG_RESET       = 16'd1000;
  localparam logic [CNT_W-1:0] DOUBLE_GAP_RESET = 16'd300;
  localparam logic [CNT_W-1:0] EDGE_RESET       = 16'd20;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

// ----- rtl/button_click_classifier_unit.sv -----
// Top level of the button click classifier: register port, classifier state and result register.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+------------------------------
//  input    | in_valid  | in_stall  | level
//  output   | out_valid | out_stall | event_res
//  config   | psel/penable/pwrite, pready always high | paddr, pwdata, prdata
//
// A word is taken per cycle unless stalled; its result is in the result register next cycle.
// The counter update and event decode sit between the state registers and that register.
// The input side stalls only while the result register is full and the output side stalls.
// A synchronous reset clears all counters, locks and the result valid flag, and loads
// the register defaults.
module button_click_classifier_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   event_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcc_pkg::DATA_W-1:0]   pwdata,
  output logic [bcc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic                        rest_level;
  logic [1:0]                  mode;
  logic [bcc_pkg::CNT_W-1:0]   short_ticks;
  logic [bcc_pkg::CNT_W-1:0]   long_ticks;
  logic [bcc_pkg::CNT_W-1:0]   double_gap_ticks;
  logic [bcc_pkg::CNT_W-1:0]   edge_ticks;

  logic [bcc_pkg::CNT_W-1:0]   hold_count, hold_count_next;
  logic [bcc_pkg::CNT_W-1:0]   gap_count, gap_count_next;
  logic [1:0]                  click_count, click_count_next;
  logic                        press_lock, press_lock_next;
  logic                        click_lock, click_lock_next;
  logic                        in_lock, in_lock_next;
  logic                        out_lock, out_lock_next;
  bcc_pkg::ev_t                ev_next;

  logic                        accept;
  logic                        cfg_write;
  logic                        at_rest;
  logic [2:0]                  reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[4:2];
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign at_rest   = (level == rest_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_level       <= 1'b0;
      mode             <= bcc_pkg::MODE_CLICK;
      short_ticks      <= bcc_pkg::SHORT_RESET;
      long_ticks       <= bcc_pkg::LONG_RESET;
      double_gap_ticks <= bcc_pkg::DOUBLE_GAP_RESET;
      edge_ticks       <= bcc_pkg::EDGE_RESET;
    end else if (cfg_write && (paddr[1:0] == 2'b00)) begin
      case (reg_sel)
        bcc_pkg::REG_REST_LEVEL: rest_level       <= pwdata[0];
        bcc_pkg::REG_MODE:       mode             <= pwdata[1:0];
        bcc_pkg::REG_SHORT:      short_ticks      <= pwdata[bcc_pkg::CNT_W-1:0];
        bcc_pkg::REG_LONG:       long_ticks       <= pwdata[bcc_pkg::CNT_W-1:0];
        bcc_pkg::REG_DOUBLE_GAP: double_gap_ticks <= pwdata[bcc_pkg::CNT_W-1:0];
        bcc_pkg::REG_EDGE:       edge_ticks       <= pwdata[bcc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      bcc_pkg::REG_REST_LEVEL: prdata = {{(bcc_pkg::DATA_W-1){1'b0}}, rest_level};
      bcc_pkg::REG_MODE:       prdata = {{(bcc_pkg::DATA_W-2){1'b0}}, mode};
      bcc_pkg::REG_SHORT:
        prdata = {{(bcc_pkg::DATA_W-bcc_pkg::CNT_W){1'b0}}, short_ticks};
      bcc_pkg::REG_LONG:
        prdata = {{(bcc_pkg::DATA_W-bcc_pkg::CNT_W){1'b0}}, long_ticks};
      bcc_pkg::REG_DOUBLE_GAP:
        prdata = {{(bcc_pkg::DATA_W-bcc_pkg::CNT_W){1'b0}}, double_gap_ticks};
      bcc_pkg::REG_EDGE:
        prdata = {{(bcc_pkg::DATA_W-bcc_pkg::CNT_W){1'b0}}, edge_ticks};
      default: prdata = '0;
    endcase
  end

  // Later checks in the click path see the values left by earlier ones, as a long press
  // after a double press in the same tick must not fire.
  always_comb begin
    hold_count_next  = hold_count;
    gap_count_next   = gap_count;
    click_count_next = click_count;
    press_lock_next  = press_lock;
    click_lock_next  = click_lock;
    in_lock_next     = in_lock;
    out_lock_next    = out_lock;
    ev_next          = bcc_pkg::EV_NONE;
    case (mode)
      bcc_pkg::MODE_CLICK: begin
        if (at_rest) begin
          press_lock_next = 1'b0;
          hold_count_next = '0;
          click_lock_next = 1'b0;
          if (click_count != 2'd0) begin
            gap_count_next = bcc_pkg::sat_inc(gap_count);
            if (gap_count_next > double_gap_ticks) begin
              ev_next          = bcc_pkg::EV_SINGLE;
              gap_count_next   = '0;
              click_count_next = 2'd0;
            end
          end
        end else if (!press_lock) begin
          hold_count_next = bcc_pkg::sat_inc(hold_count);
          if (hold_count_next > short_ticks) begin
            if (!click_lock) begin
              click_lock_next = 1'b1;
              if (click_count != 2'd3) begin
                click_count_next = click_count + 2'd1;
              end
            end
            if (click_count_next > 2'd1) begin
              click_count_next = 2'd0;
              hold_count_next  = '0;
              press_lock_next  = 1'b1;
              ev_next          = bcc_pkg::EV_DOUBLE;
            end
          end
          if (hold_count_next > long_ticks) begin
            hold_count_next  = '0;
            click_lock_next  = 1'b0;
            press_lock_next  = 1'b1;
            click_count_next = 2'd0;
            ev_next          = bcc_pkg::EV_LONG;
          end
        end
      end
      bcc_pkg::MODE_BOTHWAY: begin
        if (at_rest) begin
          in_lock_next = 1'b0;
          if (!out_lock) begin
            hold_count_next = bcc_pkg::sat_inc(hold_count);
            if (hold_count_next > edge_ticks) begin
              hold_count_next = '0;
              out_lock_next   = 1'b1;
              ev_next         = bcc_pkg::EV_OUT;
            end
          end
        end else if (!in_lock) begin
          out_lock_next   = 1'b0;
          hold_count_next = bcc_pkg::sat_inc(hold_count);
          if (hold_count_next > edge_ticks) begin
            hold_count_next = '0;
            in_lock_next    = 1'b1;
            ev_next         = bcc_pkg::EV_IN;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count  <= '0;
      gap_count   <= '0;
      click_count <= 2'd0;
      press_lock  <= 1'b0;
      click_lock  <= 1'b0;
      in_lock     <= 1'b0;
      out_lock    <= 1'b0;
    end else if (accept) begin
      hold_count  <= hold_count_next;
      gap_count   <= gap_count_next;
      click_count <= click_count_next;
      press_lock  <= press_lock_next;
      click_lock  <= click_lock_next;
      in_lock     <= in_lock_next;
      out_lock    <= out_lock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res <= ev_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result register not empty after reset");

  a_idle_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(hold_count) && $stable(gap_count) && $stable(click_count))
    else $error("counters changed without an accepted word");

  a_combo_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == bcc_pkg::MODE_COMBO) |=> event_res == bcc_pkg::EV_NONE)
    else $error("event reported in combination mode");
`endif

endmodule
